>>> sv/m3i_pkg.sv
package m3i_pkg;

    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned ENT_W         = 32;
    localparam int unsigned N_ENT         = 9;
    localparam int unsigned N_ROW         = 3;
    localparam int unsigned CM_W          = 2 * ENT_W;
    localparam int unsigned DM_W          = 3 * ENT_W;
    localparam int unsigned DET_W         = DM_W + 1;
    localparam int unsigned DEN_W         = DM_W + 1;
    localparam int unsigned Q_W           = ENT_W;
    localparam int unsigned Q_DEPTH       = 4;
    localparam int unsigned Q_IDX_W       = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W       = $clog2(Q_DEPTH + 1);

    // cofactor of inverse entry k = m[0]*m[1] - m[2]*m[3] of this row
    localparam int unsigned COF_IDX [N_ENT][4] = '{
        '{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{3, 2, 0, 5},
        '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
    };

    typedef struct packed {
        logic signed [ENT_W-1:0] in_r0c0;
        logic signed [ENT_W-1:0] in_r0c1;
        logic signed [ENT_W-1:0] in_r0c2;
        logic signed [ENT_W-1:0] in_r1c0;
        logic signed [ENT_W-1:0] in_r1c1;
        logic signed [ENT_W-1:0] in_r1c2;
        logic signed [ENT_W-1:0] in_r2c0;
        logic signed [ENT_W-1:0] in_r2c1;
        logic signed [ENT_W-1:0] in_r2c2;
    } in_t;

    typedef struct packed {
        logic signed [ENT_W-1:0] out_r0c0;
        logic signed [ENT_W-1:0] out_r0c1;
        logic signed [ENT_W-1:0] out_r0c2;
        logic signed [ENT_W-1:0] out_r1c0;
        logic signed [ENT_W-1:0] out_r1c1;
        logic signed [ENT_W-1:0] out_r1c2;
        logic signed [ENT_W-1:0] out_r2c0;
        logic signed [ENT_W-1:0] out_r2c1;
        logic signed [ENT_W-1:0] out_r2c2;
        logic                    singular;
        logic                    saturated;
    } out_t;

    typedef struct packed {
        logic                             singular;
        logic [DM_W-1:0]                  dmag;
        logic [N_ENT-1:0]                 neg;
        logic [N_ENT-1:0][CM_W-1:0]       cmag;
    } work_t;

endpackage

>>> sv/m3i_front.sv
module m3i_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid,
    output logic            stall,
    input  m3i_pkg::in_t    item,
    output logic            push,
    input  logic            full,
    output m3i_pkg::work_t  work
);
    import m3i_pkg::*;

    localparam int unsigned NSTG = 6;

    logic signed [ENT_W-1:0]   m [N_ENT];
    logic [NSTG-1:0]           vld_reg;
    logic                      en;

    logic signed [CM_W-1:0]    prod_reg [2*N_ENT];
    logic signed [ENT_W-1:0]   mrow1_reg [N_ROW];
    logic signed [ENT_W-1:0]   mrow2_reg [N_ROW];
    logic signed [CM_W-1:0]    cof2_reg [N_ENT];
    logic signed [CM_W-1:0]    cof3_reg [N_ENT];
    logic signed [CM_W-1:0]    cof4_reg [N_ENT];
    logic signed [CM_W-1:0]    cof5_reg [N_ENT];
    logic signed [CM_W:0]      plo_reg [N_ROW];
    logic signed [CM_W-1:0]    phi_reg [N_ROW];
    logic signed [DET_W-1:0]   term_reg [N_ROW];
    logic signed [DET_W-1:0]   det_reg;
    logic signed [DET_W-1:0]   dabs;
    logic                      dneg;
    work_t                     work_reg;
    work_t                     work_next;

    assign en    = !(vld_reg[NSTG-1] && full);
    assign stall = !en;
    assign push  = vld_reg[NSTG-1] && !full;
    assign work  = work_reg;

    always_comb
    begin
        m[0] = item.in_r0c0;
        m[1] = item.in_r0c1;
        m[2] = item.in_r0c2;
        m[3] = item.in_r1c0;
        m[4] = item.in_r1c1;
        m[5] = item.in_r1c2;
        m[6] = item.in_r2c0;
        m[7] = item.in_r2c1;
        m[8] = item.in_r2c2;
    end

    always_comb
    begin
        dneg                = det_reg[DET_W-1];
        dabs                = dneg ? -det_reg : det_reg;
        work_next.singular  = (det_reg == '0);
        work_next.dmag      = dabs[DM_W-1:0];
        for (int k = 0; k < N_ENT; k++)
        begin
            work_next.neg[k]  = cof5_reg[k][CM_W-1] ^ dneg;
            work_next.cmag[k] = cof5_reg[k][CM_W-1] ? -cof5_reg[k] : cof5_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N_ENT; k++)
            begin
                prod_reg[2*k]   <= m[COF_IDX[k][0]] * m[COF_IDX[k][1]];
                prod_reg[2*k+1] <= m[COF_IDX[k][2]] * m[COF_IDX[k][3]];
                cof2_reg[k]     <= prod_reg[2*k] - prod_reg[2*k+1];
                cof3_reg[k]     <= cof2_reg[k];
                cof4_reg[k]     <= cof3_reg[k];
                cof5_reg[k]     <= cof4_reg[k];
            end
            // determinant by expansion along row 0
            for (int j = 0; j < N_ROW; j++)
            begin
                mrow1_reg[j] <= m[j];
                mrow2_reg[j] <= mrow1_reg[j];
                plo_reg[j]   <= $signed({1'b0, cof2_reg[3*j][ENT_W-1:0]}) * mrow2_reg[j];
                phi_reg[j]   <= $signed(cof2_reg[3*j][CM_W-1:ENT_W]) * mrow2_reg[j];
                term_reg[j]  <= (DET_W'(phi_reg[j]) <<< ENT_W) + DET_W'(plo_reg[j]);
            end
            det_reg  <= term_reg[0] + term_reg[1] + term_reg[2];
            work_reg <= work_next;
        end
    end

endmodule

>>> sv/m3i_queue.sv
module m3i_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  m3i_pkg::work_t  wdata,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output m3i_pkg::work_t  rdata
);
    import m3i_pkg::*;

    work_t                 mem [Q_DEPTH];
    logic [Q_IDX_W-1:0]    wr_ptr_reg;
    logic [Q_IDX_W-1:0]    wr_ptr_next;
    logic [Q_IDX_W-1:0]    rd_ptr_reg;
    logic [Q_IDX_W-1:0]    rd_ptr_next;
    logic [Q_CNT_W-1:0]    cnt_reg;
    logic [Q_CNT_W-1:0]    cnt_next;

    assign full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> sv/m3i_div_lane.sv
module m3i_div_lane #(
    parameter int unsigned FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [m3i_pkg::CM_W-1:0]      cmag,
    input  logic [m3i_pkg::DM_W-1:0]      dmag,
    input  logic                          neg_in,
    input  logic [m3i_pkg::DEN_W-1:0]     den [m3i_pkg::Q_W+1],
    output logic [m3i_pkg::Q_W-1:0]       q,
    output logic                          ovf,
    output logic                          neg
);
    import m3i_pkg::*;

    localparam int unsigned SH    = 2 * FRAC_BITS + 1;
    localparam int unsigned NUM_W = ((CM_W + SH > DM_W) ? CM_W + SH : DM_W) + 1;
    localparam int unsigned HI_W  = NUM_W - Q_W;
    localparam int unsigned CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [NUM_W-1:0]   num_a_reg;
    logic               neg_a_reg;
    logic [HI_W-1:0]    hi;
    logic [DEN_W-1:0]   rem_reg [Q_W];
    logic [Q_W-1:0]     qs_reg [Q_W+1];
    logic               ovf_reg [Q_W+1];
    logic               neg_reg [Q_W+1];
    logic [DEN_W:0]     trial [Q_W];
    logic               ge [Q_W];
    logic [DEN_W-1:0]   rnew [Q_W-1];

    assign hi  = num_a_reg[NUM_W-1:Q_W];
    assign q   = qs_reg[Q_W];
    assign ovf = ovf_reg[Q_W];
    assign neg = neg_reg[Q_W];

    // restoring division, one quotient bit per stage
    always_comb
    begin
        for (int i = 0; i < Q_W; i++)
        begin
            trial[i] = {rem_reg[i], qs_reg[i][Q_W-1]};
            ge[i]    = (trial[i] >= {1'b0, den[i+1]});
        end
        for (int i = 0; i < Q_W - 1; i++)
        begin
            rnew[i] = ge[i] ? DEN_W'(trial[i] - {1'b0, den[i+1]}) : trial[i][DEN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_a_reg  <= (NUM_W'(cmag) << SH) + NUM_W'(dmag);
            neg_a_reg  <= neg_in;
            ovf_reg[0] <= (CMP_W'(hi) >= CMP_W'(den[0]));
            rem_reg[0] <= DEN_W'(hi);
            qs_reg[0]  <= num_a_reg[Q_W-1:0];
            neg_reg[0] <= neg_a_reg;
            for (int i = 0; i < Q_W; i++)
            begin
                qs_reg[i+1]  <= {qs_reg[i][Q_W-2:0], ge[i]};
                ovf_reg[i+1] <= ovf_reg[i];
                neg_reg[i+1] <= neg_reg[i];
            end
            for (int i = 0; i < Q_W - 1; i++)
            begin
                rem_reg[i+1] <= rnew[i];
            end
        end
    end

endmodule

>>> sv/m3i_back.sv
module m3i_back #(
    parameter int unsigned FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            empty,
    input  m3i_pkg::work_t  head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output m3i_pkg::out_t   out_data
);
    import m3i_pkg::*;

    localparam int unsigned NCTL = Q_W + 3;

    logic                 en;
    logic [NCTL-1:0]      vld_reg;
    logic [NCTL-1:0]      sng_reg;
    work_t                b0_reg;
    logic [DEN_W-1:0]     den_reg [Q_W+1];
    logic [Q_W-1:0]       q_w [N_ENT];
    logic [N_ENT-1:0]     ovf_w;
    logic [N_ENT-1:0]     neg_w;
    logic [Q_W-1:0]       lim [N_ENT];
    logic [Q_W-1:0]       vsel [N_ENT];
    logic [ENT_W-1:0]     res [N_ENT];
    logic [N_ENT-1:0]     sat_ent;
    logic                 out_valid_reg;
    out_t                 out_reg;
    out_t                 out_next;

    assign en        = !(out_valid_reg && out_stall);
    assign pop       = en && !empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    for (genvar k = 0; k < N_ENT; k++)
    begin : g_lane
        m3i_div_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk    (clk),
            .en     (en),
            .cmag   (b0_reg.cmag[k]),
            .dmag   (b0_reg.dmag),
            .neg_in (b0_reg.neg[k]),
            .den    (den_reg),
            .q      (q_w[k]),
            .ovf    (ovf_w[k]),
            .neg    (neg_w[k])
        );
    end

    // round-trip sign, clip to range, zero a singular beat
    always_comb
    begin
        for (int k = 0; k < N_ENT; k++)
        begin
            lim[k]     = neg_w[k] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
            sat_ent[k] = ovf_w[k] || (q_w[k] > lim[k]);
            vsel[k]    = sat_ent[k] ? lim[k] : q_w[k];
            res[k]     = neg_w[k] ? -vsel[k] : vsel[k];
            if (sng_reg[NCTL-1])
            begin
                res[k]     = '0;
                sat_ent[k] = 1'b0;
            end
        end
        out_next.out_r0c0  = res[0];
        out_next.out_r0c1  = res[1];
        out_next.out_r0c2  = res[2];
        out_next.out_r1c0  = res[3];
        out_next.out_r1c1  = res[4];
        out_next.out_r1c2  = res[5];
        out_next.out_r2c0  = res[6];
        out_next.out_r2c1  = res[7];
        out_next.out_r2c2  = res[8];
        out_next.singular  = sng_reg[NCTL-1];
        out_next.saturated = |sat_ent;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[NCTL-2:0], pop};
            out_valid_reg <= vld_reg[NCTL-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_reg     <= head;
            sng_reg    <= {sng_reg[NCTL-2:0], head.singular};
            den_reg[0] <= {b0_reg.dmag, 1'b0};
            for (int i = 1; i <= Q_W; i++)
            begin
                den_reg[i] <= den_reg[i-1];
            end
            out_reg    <= out_next;
        end
    end

endmodule

>>> sv/mat3_inverse.sv
// 3x3 matrix inverse, signed fixed point with FRAC_BITS fraction bits.
// Input channel mat: one beat carries a whole matrix, row-major, and is
// taken when mat_valid is high and mat_stall is low.
// Output channel inv: one beat per matrix, in order, taken when inv_valid
// is high and inv_stall is low. Entries are rounded to nearest and clipped
// to the 32-bit range, with saturated set when any entry was clipped.
// A zero determinant gives all-zero entries with singular set.
// Throughput: one matrix per cycle with no stall on the output.
// The result passes through the six-stage determinant and cofactor
// pipeline, the four-entry queue and the restoring divider lanes, one
// quotient bit per stage over 32 stages.
// While a result beat waits under inv_stall the divider pipeline holds;
// the front pipeline keeps taking matrices until the queue is full and a
// matrix waits at its end, then raises mat_stall.
// Reset empties both pipelines and the queue; no beat is shown after it
// until a new matrix has passed through.
module mat3_inverse #(
    parameter int unsigned FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           mat_valid,
    output logic           mat_stall,
    input  m3i_pkg::in_t   mat,
    output logic           inv_valid,
    input  logic           inv_stall,
    output m3i_pkg::out_t  inv
);
    import m3i_pkg::*;

    logic   push;
    logic   full;
    logic   pop;
    logic   empty;
    work_t  wdata;
    work_t  rdata;

    m3i_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (mat_valid),
        .stall (mat_stall),
        .item  (mat),
        .push  (push),
        .full  (full),
        .work  (wdata)
    );

    m3i_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wdata),
        .full  (full),
        .pop   (pop),
        .empty (empty),
        .rdata (rdata)
    );

    m3i_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .head      (rdata),
        .pop       (pop),
        .out_valid (inv_valid),
        .out_stall (inv_stall),
        .out_data  (inv)
    );

endmodule

>>> sv/m3i_check.sv
module m3i_check (
    input logic           clk,
    input logic           rst_n,
    input logic           inv_valid,
    input logic           inv_stall,
    input m3i_pkg::out_t  inv
);
    import m3i_pkg::*;

    localparam logic [ENT_W-1:0] POS_LIM = {1'b0, {(ENT_W-1){1'b1}}};
    localparam logic [ENT_W-1:0] NEG_LIM = {1'b1, {(ENT_W-1){1'b0}}};

    logic all_zero;
    logic hit_lim;

    always_comb
    begin
        all_zero = (inv.out_r0c0 == '0) && (inv.out_r0c1 == '0) && (inv.out_r0c2 == '0)
                && (inv.out_r1c0 == '0) && (inv.out_r1c1 == '0) && (inv.out_r1c2 == '0)
                && (inv.out_r2c0 == '0) && (inv.out_r2c1 == '0) && (inv.out_r2c2 == '0);
        hit_lim  = (inv.out_r0c0 == POS_LIM) || (inv.out_r0c0 == NEG_LIM)
                || (inv.out_r0c1 == POS_LIM) || (inv.out_r0c1 == NEG_LIM)
                || (inv.out_r0c2 == POS_LIM) || (inv.out_r0c2 == NEG_LIM)
                || (inv.out_r1c0 == POS_LIM) || (inv.out_r1c0 == NEG_LIM)
                || (inv.out_r1c1 == POS_LIM) || (inv.out_r1c1 == NEG_LIM)
                || (inv.out_r1c2 == POS_LIM) || (inv.out_r1c2 == NEG_LIM)
                || (inv.out_r2c0 == POS_LIM) || (inv.out_r2c0 == NEG_LIM)
                || (inv.out_r2c1 == POS_LIM) || (inv.out_r2c1 == NEG_LIM)
                || (inv.out_r2c2 == POS_LIM) || (inv.out_r2c2 == NEG_LIM);
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && inv_stall |=> inv_valid)
        else $error("result beat dropped under stall");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !inv_valid)
        else $error("result beat shown straight after reset");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && inv.singular |-> all_zero && !inv.saturated)
        else $error("singular beat with nonzero entries or clip flag");

    a_sat_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && inv.saturated |-> hit_lim)
        else $error("clip flag without a clipped entry");

endmodule

bind mat3_inverse m3i_check u_m3i_check (.*);
